### rtl/core/hbridge_direction_dead_time_display_defines.svh
// Shared assertion macros; they use the clk and arst_n names of the asserting scope.
`ifndef HBRIDGE_DIRECTION_DEAD_TIME_DISPLAY_DEFINES_SVH
`define HBRIDGE_DIRECTION_DEAD_TIME_DISPLAY_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define HBDTD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define HBDTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/hbdtd_pkg.sv
package hbdtd_pkg;

	localparam int unsigned PWM_FULL_DEFAULT = 4095;

	localparam int SAMPLE_W  = 12;
	localparam int PCT_W     = 7;
	localparam int FRAME_W   = 8;
	localparam int PHASE_W   = 3;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [SAMPLE_W-1:0] PCT_DIV = 12'd4095;
	localparam logic [PCT_W-1:0]    PCT_MAX = 7'd100;

	localparam logic [FRAME_W-1:0] DEAD_RESET = 8'd100;
	localparam logic [FRAME_W-1:0] DEB_RESET  = 8'd40;
	localparam logic [FRAME_W-1:0] HOLD_RESET = 8'd20;

	localparam logic [1:0] REG_DEAD = 2'd0;
	localparam logic [1:0] REG_DEB  = 2'd1;
	localparam logic [1:0] REG_HOLD = 2'd2;

	localparam logic [PHASE_W-1:0] PH_HOLD   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_DEAD_L = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DEB_L  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_REL_L  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DEAD_R = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DEB_R  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_REL_R  = 3'd6;

	localparam logic [1:0] SLOT_HUNDREDS = 2'd0;
	localparam logic [1:0] SLOT_TENS     = 2'd1;
	localparam logic [1:0] SLOT_UNITS    = 2'd2;

	// seven segments a..g in bits 0..6, active low
	function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
		logic [6:0] seg;
		case (digit)
			4'd0: seg = 7'h40;
			4'd1: seg = 7'h79;
			4'd2: seg = 7'h24;
			4'd3: seg = 7'h30;
			4'd4: seg = 7'h19;
			4'd5: seg = 7'h12;
			4'd6: seg = 7'h02;
			4'd7: seg = 7'h78;
			4'd8: seg = 7'h00;
			default: seg = 7'h10;
		endcase
		return seg;
	endfunction

endpackage

### rtl/core/hbridge_direction_dead_time_display.sv
// H-bridge direction control with dead time and a three-digit percent display. Each accepted
// request is one display tick: it lights one digit (hundreds, tens, units in turn) and returns
// one result with the bridge drive, the direction lamps and the segment pattern. Every third
// tick is a frame boundary where the control sequence advances: sample latch and hold, button
// checks (left first), dead time on a change of direction, debounce and wait for release. The
// block takes one request per clock: the speed percent is formed as the request enters the
// input register, and the whole frame decision runs in one pass between the input register
// and the result register, so a request passes the input register and then the result register;
// a stalled result holds the input register, which then stalls the input side.
// Configuration writes through the APB port are expected only while the block is idle.
module hbridge_direction_dead_time_display #(
	parameter int unsigned PWM_FULL = hbdtd_pkg::PWM_FULL_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [hbdtd_pkg::SAMPLE_W-1:0] speed_sample,
	input  logic                          left_button_n,
	input  logic                          right_button_n,

	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          high_left,
	output logic                          high_right,
	output logic [hbdtd_pkg::SAMPLE_W-1:0] left_low_compare,
	output logic [hbdtd_pkg::SAMPLE_W-1:0] right_low_compare,
	output logic                          lamp_dir_one,
	output logic                          lamp_dir_two,
	output logic [6:0]                    segment_pattern,
	output logic [2:0]                    digit_enable_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbdtd_pkg::PADDR_W-1:0] paddr,
	input  logic [hbdtd_pkg::PDATA_W-1:0] pwdata,
	output logic [hbdtd_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);

	localparam int SW = hbdtd_pkg::SAMPLE_W;
	localparam int PW = hbdtd_pkg::PCT_W;
	localparam int FW = hbdtd_pkg::FRAME_W;
	localparam int HW = hbdtd_pkg::PHASE_W;
	localparam int CHAIN_STEPS = 8;
	localparam logic [16:0] FULL_W = 17'(PWM_FULL);
	localparam logic [SW-1:0] FULL_OUT = FULL_W[SW-1:0];

	// config
	logic [FW-1:0] dead_q, deb_q, hold_q;
	logic          cfg_write;

	// input stage
	logic          item_valid_s1;
	logic [SW-1:0] duty_s1;
	logic [PW-1:0] pct_s1;
	logic          left_n_s1, right_n_s1;

	// control state
	logic          dir_q, driven_q;
	logic [HW-1:0] phase_q;
	logic [FW-1:0] frame_cnt_q;
	logic [1:0]    slot_q;
	logic [PW-1:0] percent_q;
	logic [SW-1:0] duty_q;

	// result stage
	logic          result_valid_s2;
	logic          high_left_s2, high_right_s2, lamp_one_s2, lamp_two_s2;
	logic [SW-1:0] left_cmp_s2, right_cmp_s2;
	logic [6:0]    seg_s2;
	logic [2:0]    digit_en_s2;

	logic          advance;

	// percent and duty of the incoming sample
	logic [18:0]   prod_in;
	logic [PW-1:0] quo_est;
	logic [12:0]   rem_est;
	logic [PW-1:0] pct_raw, pct_in;
	logic [SW-1:0] duty_in;

	// frame decision
	logic [1:0]    slot_eff, slot_nxt;
	logic [FW-1:0] hold_eff;
	logic [HW-1:0] ph_c;
	logic [FW-1:0] cnt_c;
	logic          dir_c, drv_c, latch_c, done_c;
	logic [PW-1:0] percent_nxt;
	logic [SW-1:0] duty_nxt;

	// display
	logic          hund;
	logic [PW-1:0] rem_pct;
	logic [14:0]   tens_prod;
	logic [3:0]    tens, units, digit;
	logic [16:0]   cmp_diff;
	logic [SW-1:0] cmp_drive;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= hbdtd_pkg::DEAD_RESET;
			deb_q  <= hbdtd_pkg::DEB_RESET;
			hold_q <= hbdtd_pkg::HOLD_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				hbdtd_pkg::REG_DEAD: dead_q <= pwdata[FW-1:0];
				hbdtd_pkg::REG_DEB:  deb_q  <= pwdata[FW-1:0];
				hbdtd_pkg::REG_HOLD: hold_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			hbdtd_pkg::REG_DEAD: prdata = {{(hbdtd_pkg::PDATA_W-FW){1'b0}}, dead_q};
			hbdtd_pkg::REG_DEB:  prdata = {{(hbdtd_pkg::PDATA_W-FW){1'b0}}, deb_q};
			hbdtd_pkg::REG_HOLD: prdata = {{(hbdtd_pkg::PDATA_W-FW){1'b0}}, hold_q};
			default:             prdata = '0;
		endcase
	end

	// sample * 100 / 4095: estimate with >> 12, one correction
	always_comb begin
		prod_in = {1'b0, speed_sample, 6'b0} + {2'b0, speed_sample, 5'b0}
			+ {5'b0, speed_sample, 2'b0};
		quo_est = prod_in[18:12];
		rem_est = {1'b0, prod_in[11:0]} + {6'b0, quo_est};
		pct_raw = quo_est + PW'(rem_est >= {1'b0, hbdtd_pkg::PCT_DIV});
		pct_in  = (pct_raw > hbdtd_pkg::PCT_MAX) ? hbdtd_pkg::PCT_MAX : pct_raw;
		duty_in = ({5'b0, speed_sample} > FULL_W) ? FULL_OUT : speed_sample;
	end

	assign advance    = item_valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			duty_s1    <= duty_in;
			pct_s1     <= pct_in;
			left_n_s1  <= left_button_n;
			right_n_s1 <= right_button_n;
		end
	end

	assign slot_eff = (slot_q > hbdtd_pkg::SLOT_UNITS) ? hbdtd_pkg::SLOT_HUNDREDS : slot_q;
	assign slot_nxt = (slot_eff == hbdtd_pkg::SLOT_UNITS) ? hbdtd_pkg::SLOT_HUNDREDS
		: slot_eff + 2'd1;
	assign hold_eff = (hold_q == '0) ? FW'(1) : hold_q;

	// a boundary can chain several phases in one tick; it settles within the CHAIN_STEPS unrolled steps
	always_comb begin
		ph_c    = phase_q;
		cnt_c   = frame_cnt_q;
		dir_c   = dir_q;
		drv_c   = driven_q;
		latch_c = 1'b0;
		done_c  = (slot_eff != hbdtd_pkg::SLOT_HUNDREDS);
		for (int i = 0; i < CHAIN_STEPS; i++) begin
			if (!done_c) begin
				case (ph_c)
					hbdtd_pkg::PH_HOLD: begin
						if (cnt_c == '0)
							latch_c = 1'b1;
						if (cnt_c < hold_eff) begin
							cnt_c  = cnt_c + FW'(1);
							done_c = 1'b1;
						end else if (!left_n_s1) begin
							cnt_c = '0;
							if (dir_c) begin
								drv_c = 1'b0;
								ph_c  = hbdtd_pkg::PH_DEAD_L;
							end else begin
								ph_c = hbdtd_pkg::PH_DEB_L;
							end
						end else if (!right_n_s1) begin
							cnt_c = '0;
							if (!dir_c) begin
								drv_c = 1'b0;
								ph_c  = hbdtd_pkg::PH_DEAD_R;
							end else begin
								ph_c = hbdtd_pkg::PH_DEB_R;
							end
						end else begin
							drv_c = 1'b1;
							cnt_c = '0;
							ph_c  = hbdtd_pkg::PH_HOLD;
						end
					end
					hbdtd_pkg::PH_DEAD_L, hbdtd_pkg::PH_DEAD_R: begin
						if (cnt_c < dead_q) begin
							cnt_c  = cnt_c + FW'(1);
							done_c = 1'b1;
						end else begin
							dir_c = (ph_c == hbdtd_pkg::PH_DEAD_R);
							drv_c = 1'b1;
							cnt_c = '0;
							ph_c  = dir_c ? hbdtd_pkg::PH_DEB_R : hbdtd_pkg::PH_DEB_L;
						end
					end
					hbdtd_pkg::PH_DEB_L, hbdtd_pkg::PH_DEB_R: begin
						if (cnt_c < deb_q) begin
							cnt_c  = cnt_c + FW'(1);
							done_c = 1'b1;
						end else begin
							ph_c = (ph_c == hbdtd_pkg::PH_DEB_R) ? hbdtd_pkg::PH_REL_R
								: hbdtd_pkg::PH_REL_L;
						end
					end
					hbdtd_pkg::PH_REL_L: begin
						if (!left_n_s1) begin
							done_c = 1'b1;
						end else if (!right_n_s1) begin
							cnt_c = '0;
							if (!dir_c) begin
								drv_c = 1'b0;
								ph_c  = hbdtd_pkg::PH_DEAD_R;
							end else begin
								ph_c = hbdtd_pkg::PH_DEB_R;
							end
						end else begin
							drv_c = 1'b1;
							cnt_c = '0;
							ph_c  = hbdtd_pkg::PH_HOLD;
						end
					end
					hbdtd_pkg::PH_REL_R: begin
						if (!right_n_s1) begin
							done_c = 1'b1;
						end else begin
							drv_c = 1'b1;
							cnt_c = '0;
							ph_c  = hbdtd_pkg::PH_HOLD;
						end
					end
					default: begin
						drv_c = 1'b1;
						cnt_c = '0;
						ph_c  = hbdtd_pkg::PH_HOLD;
					end
				endcase
			end
		end
	end

	assign percent_nxt = latch_c ? pct_s1 : percent_q;
	assign duty_nxt    = latch_c ? duty_s1 : duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= 1'b0;
			driven_q    <= 1'b0;
			phase_q     <= hbdtd_pkg::PH_HOLD;
			frame_cnt_q <= '0;
			slot_q      <= hbdtd_pkg::SLOT_HUNDREDS;
			percent_q   <= '0;
			duty_q      <= '0;
		end else if (advance) begin
			dir_q       <= dir_c;
			driven_q    <= drv_c;
			phase_q     <= ph_c;
			frame_cnt_q <= cnt_c;
			slot_q      <= slot_nxt;
			percent_q   <= percent_nxt;
			duty_q      <= duty_nxt;
		end
	end

	// digit split: tens = rem * 205 >> 11, exact below 1029
	always_comb begin
		hund      = (percent_nxt >= hbdtd_pkg::PCT_MAX);
		rem_pct   = hund ? percent_nxt - hbdtd_pkg::PCT_MAX : percent_nxt;
		tens_prod = 15'(rem_pct) * 15'd205;
		tens      = tens_prod[14:11];
		units     = 4'(rem_pct - PW'(tens) * PW'(10));
		case (slot_eff)
			hbdtd_pkg::SLOT_HUNDREDS: digit = {3'b0, hund};
			hbdtd_pkg::SLOT_TENS:     digit = tens;
			default:                  digit = units;
		endcase
		if (digit > 4'd9)
			digit = 4'd9;
		cmp_diff  = FULL_W - {5'b0, duty_nxt};
		cmp_drive = cmp_diff[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			high_left_s2  <= drv_c && !dir_c;
			high_right_s2 <= drv_c && dir_c;
			left_cmp_s2   <= (drv_c && dir_c) ? cmp_drive : FULL_OUT;
			right_cmp_s2  <= (drv_c && !dir_c) ? cmp_drive : FULL_OUT;
			lamp_one_s2   <= !dir_c;
			lamp_two_s2   <= dir_c;
			seg_s2        <= hbdtd_pkg::seg_pattern(digit);
			digit_en_s2   <= ~(3'b001 << slot_eff);
		end
	end

	assign result_valid      = result_valid_s2;
	assign high_left         = high_left_s2;
	assign high_right        = high_right_s2;
	assign left_low_compare  = left_cmp_s2;
	assign right_low_compare = right_cmp_s2;
	assign lamp_dir_one      = lamp_one_s2;
	assign lamp_dir_two      = lamp_two_s2;
	assign segment_pattern   = seg_s2;
	assign digit_enable_n    = digit_en_s2;

endmodule

### rtl/core/hbdtd_checker.sv
`include "hbridge_direction_dead_time_display_defines.svh"

module hbdtd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic       high_left,
	input logic       high_right,
	input logic       lamp_dir_one,
	input logic       lamp_dir_two,
	input logic [6:0] segment_pattern,
	input logic [2:0] digit_enable_n
);

	`HBDTD_ASSERT(a_one_digit, !result_valid || $onehot(~digit_enable_n), "not one digit enabled")
	`HBDTD_ASSERT(a_no_shoot, !result_valid || !(high_left && high_right), "both high sides on")
	`HBDTD_ASSERT(a_lamps, !result_valid || (lamp_dir_one != lamp_dir_two), "lamps disagree")
	`HBDTD_ASSERT(a_side_dir, !result_valid || !high_left || lamp_dir_one, "drive against lamp")
	`HBDTD_ASSERT_NEXT(a_hold, result_valid && result_stall,
		result_valid && $stable(segment_pattern) && $stable(digit_enable_n), "stalled request changed")

endmodule

bind hbridge_direction_dead_time_display hbdtd_checker u_hbdtd_checker (.*);
